/* rtl/core/xiph_rtp_fragmenter_top_assert.svh */
// ----------------------------------------------------------------------------
// Xiph RTP fragmenter assertion macros
// Concurrent checks sampled on clk, disabled during rst.
// ----------------------------------------------------------------------------
`ifndef XIPH_RTP_FRAGMENTER_TOP_ASSERT_SVH
`define XIPH_RTP_FRAGMENTER_TOP_ASSERT_SVH

// Same-cycle implication.
`define XRF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define XRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/xrf_pkg.sv */
// ----------------------------------------------------------------------------
// xrf_pkg
// Constants, codes and queue entry type of the Xiph RTP fragmenter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package xrf_pkg;

  localparam int unsigned MAX_PAYLOAD = 1434;
  localparam int unsigned HDR_BYTES   = 6;
  localparam logic [15:0] MAX_PAYLOAD_W = 16'(MAX_PAYLOAD);
  localparam logic [15:0] HDR_BYTES_W   = 16'(HDR_BYTES);

  localparam logic [7:0] TYPE_WHOLE  = 8'h01;
  localparam logic [7:0] TYPE_FIRST  = 8'(1 << 6);
  localparam logic [7:0] TYPE_MIDDLE = 8'(2 << 6);
  localparam logic [7:0] TYPE_LAST   = 8'(3 << 6);

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] PH_IDENT_HI = 3'd0;
  localparam logic [2:0] PH_IDENT_MD = 3'd1;
  localparam logic [2:0] PH_IDENT_LO = 3'd2;
  localparam logic [2:0] PH_TYPE     = 3'd3;
  localparam logic [2:0] PH_SIZE_HI  = 3'd4;
  localparam logic [2:0] PH_SIZE_LO  = 3'd5;
  localparam logic [2:0] PH_PAYLOAD  = 3'd6;

  typedef struct packed {
    logic        hdr;
    logic [7:0]  frag_type;
    logic [15:0] frag_size;
    logic        hdr_marker;
    logic        pay_marker;
    logic        frag_end;
    logic [7:0]  data;
    logic [31:0] present_time;
    logic [31:0] delivery_time;
    logic [31:0] frame_length;
  } entry_t;

endpackage
`default_nettype wire

/* rtl/core/xrf_front.sv */
// ----------------------------------------------------------------------------
// xrf_front
// Accepts input bytes, tracks packet and fragment counts, classifies each
// byte and pushes one queue entry per byte that produces output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module xrf_front import xrf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire logic        q_full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        packet_start,
  input  wire logic [15:0] packet_length,
  input  wire logic [31:0] present_time,
  input  wire logic [31:0] delivery_time,
  input  wire logic [31:0] frame_length,
  output logic             enq,
  output entry_t           enq_entry
);

  logic [15:0] pkt_left;
  logic [15:0] frag_left;
  logic        first_pending;
  logic [31:0] saved_present;
  logic [31:0] saved_delivery;
  logic [31:0] saved_frame;

  logic [15:0] pkt_left_next;
  logic [15:0] frag_left_next;
  logic        first_pending_next;

  logic [15:0] eff_pl;
  logic [15:0] eff_fl;
  logic        eff_first;
  logic        drop;
  logic        fits;
  logic        open_frag;
  logic [15:0] frag;
  logic [15:0] fl2;
  logic        accept;

  assign accept = push && !q_full;

  always_comb begin
    eff_pl    = pkt_left;
    eff_fl    = frag_left;
    eff_first = first_pending;
    drop      = 1'b0;
    if (packet_start) begin
      eff_pl    = (packet_length == 16'd0) ? 16'd1 : packet_length;
      eff_fl    = 16'd0;
      eff_first = 1'b1;
    end else if (pkt_left == 16'd0) begin
      drop = 1'b1;
    end

    fits      = eff_pl <= MAX_PAYLOAD_W;
    open_frag = eff_fl == 16'd0;
    frag      = fits ? eff_pl : MAX_PAYLOAD_W;
    fl2       = open_frag ? frag : eff_fl;

    enq_entry.hdr        = open_frag;
    if (eff_first) begin
      enq_entry.frag_type = fits ? TYPE_WHOLE : TYPE_FIRST;
    end else begin
      enq_entry.frag_type = fits ? TYPE_LAST : TYPE_MIDDLE;
    end
    enq_entry.frag_size  = frag + HDR_BYTES_W;
    enq_entry.hdr_marker = fits;
    enq_entry.pay_marker = eff_pl == fl2;
    enq_entry.frag_end   = fl2 == 16'd1;
    enq_entry.data       = data_byte;
    enq_entry.present_time  = packet_start ? present_time : saved_present;
    enq_entry.delivery_time = packet_start ? delivery_time : saved_delivery;
    enq_entry.frame_length  = packet_start ? frame_length : saved_frame;

    pkt_left_next  = eff_pl - 16'd1;
    frag_left_next = fl2 - 16'd1;
    if (pkt_left_next == 16'd0) begin
      frag_left_next     = 16'd0;
      first_pending_next = 1'b1;
    end else begin
      first_pending_next = open_frag ? 1'b0 : eff_first;
    end
  end

  assign enq = accept && !drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_left      <= 16'd0;
      frag_left     <= 16'd0;
      first_pending <= 1'b1;
    end else if (enq) begin
      pkt_left      <= pkt_left_next;
      frag_left     <= frag_left_next;
      first_pending <= first_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && packet_start) begin
      saved_present  <= present_time;
      saved_delivery <= delivery_time;
      saved_frame    <= frame_length;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/xrf_queue.sv */
// ----------------------------------------------------------------------------
// xrf_queue
// Short first-in first-out queue of classified entries between the front
// and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module xrf_queue import xrf_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   enq,
  input  wire entry_t enq_entry,
  input  wire logic   deq,
  output entry_t      head,
  output logic        q_full,
  output logic        q_empty
);

  localparam logic [QPTR_W-1:0] LAST_SLOT = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] FULL_CNT  = QCNT_W'(QUEUE_DEPTH);

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_full  = count == FULL_CNT;
  assign q_empty = count == '0;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wr_ptr] <= enq_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (enq && !deq) begin
        count <= count + 1'b1;
      end else if (deq && !enq) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/xrf_back.sv */
// ----------------------------------------------------------------------------
// xrf_back
// Expands queue entries into header and payload bytes and holds the
// oldest result in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "xiph_rtp_fragmenter_top_assert.svh"
module xrf_back import xrf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        stream_ident_we,
  input  wire logic [23:0] stream_ident,
  input  wire entry_t      head,
  input  wire logic        q_empty,
  output logic             deq,
  input  wire logic        pop,
  output logic             empty,
  output logic [7:0]       out_byte,
  output logic             fragment_end,
  output logic             rtp_marker,
  output logic             run_last,
  output logic [31:0]      present_time_out,
  output logic [31:0]      delivery_time_out,
  output logic [31:0]      frame_length_out
);

  logic [23:0] ident;
  logic [2:0]  phase;
  logic [2:0]  eff_phase;
  logic        load;
  logic [7:0]  byte_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      ident <= 24'd0;
    end else if (stream_ident_we) begin
      ident <= stream_ident;
    end
  end

  assign load      = (empty || pop) && !q_empty;
  assign eff_phase = head.hdr ? phase : PH_PAYLOAD;
  assign deq       = load && (eff_phase == PH_PAYLOAD);

  always_comb begin
    case (eff_phase)
      PH_IDENT_HI: byte_sel = ident[23:16];
      PH_IDENT_MD: byte_sel = ident[15:8];
      PH_IDENT_LO: byte_sel = ident[7:0];
      PH_TYPE:     byte_sel = head.frag_type;
      PH_SIZE_HI:  byte_sel = head.frag_size[15:8];
      PH_SIZE_LO:  byte_sel = head.frag_size[7:0];
      default:     byte_sel = head.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDENT_HI;
      empty <= 1'b1;
    end else begin
      if (load) begin
        phase <= (eff_phase == PH_PAYLOAD) ? PH_IDENT_HI : phase + 3'd1;
        empty <= 1'b0;
      end else if (pop) begin
        empty <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte          <= byte_sel;
      fragment_end      <= (eff_phase == PH_PAYLOAD) && head.frag_end;
      rtp_marker        <= (eff_phase == PH_PAYLOAD) ? head.pay_marker : head.hdr_marker;
      run_last          <= eff_phase == PH_PAYLOAD;
      present_time_out  <= head.present_time;
      delivery_time_out <= head.delivery_time;
      frame_length_out  <= head.frame_length;
    end
  end

  `XRF_ASSERT_NOW(a_phase_range, 1'b1, phase <= PH_PAYLOAD, "header phase out of range")
  `XRF_ASSERT_NOW(a_phase_head, phase != PH_IDENT_HI, !q_empty && head.hdr, "header phase without header entry")
  `XRF_ASSERT_NOW(a_hdr_byte_kept, !empty && !run_last, !q_empty, "header byte shown after entry left")
  `XRF_ASSERT_NOW(a_fend_last, !empty && fragment_end, run_last, "fragment end on header byte")

endmodule
`default_nettype wire

/* rtl/core/xiph_rtp_fragmenter_top.sv */
// ----------------------------------------------------------------------------
// xiph_rtp_fragmenter_top
// Cuts codec packets into Xiph RTP fragments with a six-byte header each.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive one packet byte per transfer with push; a
//   transfer happens when push is high and full is low. On the first byte
//   set packet_start and give packet_length and the three timing words.
//   Result queue side: while empty is low the oldest result is on the
//   result ports; it transfers when pop is high.
//   The user writes stream_ident with stream_ident_we only while the block
//   is idle; the block itself does not enforce this.
// Path: each entry is registered in the queue, then loaded into the output
//   register that drives the result ports. Throughput: one result per cycle
//   while pop stays high and the queue is not empty. A byte that opens a
//   fragment yields seven results (six header bytes and the payload byte);
//   other bytes yield one. The four-entry queue between front and back
//   absorbs part of each header burst; with back-to-back input full rises.
// Reset: counts clear, stream_ident goes to zero, both queues empty.
// Stall: when pop stays low the output register holds, the queue fills,
//   and full rises until results transfer again.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module xiph_rtp_fragmenter_top import xrf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        stream_ident_we,
  input  wire logic [23:0] stream_ident,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        packet_start,
  input  wire logic [15:0] packet_length,
  input  wire logic [31:0] present_time,
  input  wire logic [31:0] delivery_time,
  input  wire logic [31:0] frame_length,
  input  wire logic        pop,
  output logic             empty,
  output logic [7:0]       out_byte,
  output logic             fragment_end,
  output logic             rtp_marker,
  output logic             run_last,
  output logic [31:0]      present_time_out,
  output logic [31:0]      delivery_time_out,
  output logic [31:0]      frame_length_out
);

  logic   enq;
  entry_t enq_entry;
  logic   deq;
  entry_t head;
  logic   q_full;
  logic   q_empty;

  assign full = q_full;

  xrf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .q_full        (q_full),
    .data_byte     (data_byte),
    .packet_start  (packet_start),
    .packet_length (packet_length),
    .present_time  (present_time),
    .delivery_time (delivery_time),
    .frame_length  (frame_length),
    .enq           (enq),
    .enq_entry     (enq_entry)
  );

  xrf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .enq       (enq),
    .enq_entry (enq_entry),
    .deq       (deq),
    .head      (head),
    .q_full    (q_full),
    .q_empty   (q_empty)
  );

  xrf_back u_back (
    .clk               (clk),
    .rst               (rst),
    .stream_ident_we   (stream_ident_we),
    .stream_ident      (stream_ident),
    .head              (head),
    .q_empty           (q_empty),
    .deq               (deq),
    .pop               (pop),
    .empty             (empty),
    .out_byte          (out_byte),
    .fragment_end      (fragment_end),
    .rtp_marker        (rtp_marker),
    .run_last          (run_last),
    .present_time_out  (present_time_out),
    .delivery_time_out (delivery_time_out),
    .frame_length_out  (frame_length_out)
  );

endmodule
`default_nettype wire

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Xiph RTP fragmenter testbench
// Feeds codec packets byte by byte through the input queue and checks every
// header and payload byte against an in-bench model of the fragmenter.
// Directed packets cover whole and first fragments, the payload-size
// boundary, zero length, stray bytes and restarts. Random
// packets follow under phases of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import xrf_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int ITEMS_PER_PHASE = 84;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        fend;
    logic        marker;
    logic        last;
    logic [31:0] pts;
    logic [31:0] dts;
    logic [31:0] flen;
  } frag_byte_t;

  class frag_scoreboard;
    logic [23:0] ident;
    logic [15:0] pkt_left;
    logic [15:0] frag_left;
    bit          first_pending;
    logic [31:0] pts;
    logic [31:0] dts;
    logic [31:0] flen;
    frag_byte_t  expected_bytes[$];
    int          errors;
    int          bytes_in;
    int          bytes_out;
    int          ignored;
    int          frag_count[4];

    function new();
      ident = '0;
      pkt_left = '0;
      frag_left = '0;
      first_pending = 1'b1;
      pts = '0;
      dts = '0;
      flen = '0;
      errors = 0;
      bytes_in = 0;
      bytes_out = 0;
      ignored = 0;
      frag_count = '{default: 0};
    endfunction

    function void add(logic [7:0] b, logic fend, logic marker, logic last);
      expected_bytes.push_back('{out_byte: b, fend: fend, marker: marker, last: last,
                                 pts: pts, dts: dts, flen: flen});
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    // Predict the bytes caused by one accepted input byte.
    function void note_input(logic [7:0] data, logic start, logic [15:0] len,
                             logic [31:0] p, logic [31:0] d, logic [31:0] f);
      logic        fits;
      logic        mark;
      logic [15:0] frag;
      logic [15:0] size;
      logic [7:0]  ftype;
      bytes_in++;
      if (start) begin
        pts = p;
        dts = d;
        flen = f;
        pkt_left = (len == 16'd0) ? 16'd1 : len;
        frag_left = '0;
        first_pending = 1'b1;
      end else if (pkt_left == 16'd0) begin
        ignored++;
        return;
      end
      if (frag_left == 16'd0) begin
        fits = (pkt_left <= MAX_PAYLOAD_W);
        frag = fits ? pkt_left : MAX_PAYLOAD_W;
        if (first_pending) ftype = fits ? TYPE_WHOLE : TYPE_FIRST;
        else ftype = fits ? TYPE_LAST : TYPE_MIDDLE;
        frag_count[ftype[7:6]]++;
        first_pending = 1'b0;
        frag_left = frag;
        size = frag + HDR_BYTES_W;
        mark = fits;
        add(ident[23:16], 1'b0, mark, 1'b0);
        add(ident[15:8], 1'b0, mark, 1'b0);
        add(ident[7:0], 1'b0, mark, 1'b0);
        add(ftype, 1'b0, mark, 1'b0);
        add(size[15:8], 1'b0, mark, 1'b0);
        add(size[7:0], 1'b0, mark, 1'b0);
      end
      add(data, frag_left == 16'd1, pkt_left == frag_left, 1'b1);
      frag_left--;
      pkt_left--;
      if (pkt_left == 16'd0) begin
        frag_left = '0;
        first_pending = 1'b1;
      end
    endfunction

    function void check_result(frag_byte_t got);
      frag_byte_t exp;
      bytes_out++;
      if (expected_bytes.size() == 0) begin
        note_error($sformatf("unexpected byte %02h with nothing pending", got.out_byte));
        return;
      end
      exp = expected_bytes.pop_front();
      if (got.out_byte !== exp.out_byte || got.fend !== exp.fend ||
          got.marker !== exp.marker || got.last !== exp.last ||
          got.pts !== exp.pts || got.dts !== exp.dts || got.flen !== exp.flen)
        note_error($sformatf({"byte %0d: expected %02h end=%0b mrk=%0b last=%0b ",
                              "%08h/%08h/%08h, got %02h end=%0b mrk=%0b last=%0b ",
                              "%08h/%08h/%08h"},
                             bytes_out, exp.out_byte, exp.fend, exp.marker, exp.last,
                             exp.pts, exp.dts, exp.flen, got.out_byte, got.fend,
                             got.marker, got.last, got.pts, got.dts, got.flen));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        stream_ident_we;
  logic [23:0] stream_ident;
  logic        push;
  logic        full;
  logic [7:0]  data_byte;
  logic        packet_start;
  logic [15:0] packet_length;
  logic [31:0] present_time;
  logic [31:0] delivery_time;
  logic [31:0] frame_length;
  logic        pop;
  logic        empty;
  logic [7:0]  out_byte;
  logic        fragment_end;
  logic        rtp_marker;
  logic        run_last;
  logic [31:0] present_time_out;
  logic [31:0] delivery_time_out;
  logic [31:0] frame_length_out;

  frag_scoreboard sb;
  int sender_idle_pct;
  int receiver_stall_pct;
  int quiet_cycles;

  xiph_rtp_fragmenter_top u_top (
    .clk              (clk),
    .rst              (rst),
    .stream_ident_we  (stream_ident_we),
    .stream_ident     (stream_ident),
    .push             (push),
    .full             (full),
    .data_byte        (data_byte),
    .packet_start     (packet_start),
    .packet_length    (packet_length),
    .present_time     (present_time),
    .delivery_time    (delivery_time),
    .frame_length     (frame_length),
    .pop              (pop),
    .empty            (empty),
    .out_byte         (out_byte),
    .fragment_end     (fragment_end),
    .rtp_marker       (rtp_marker),
    .run_last         (run_last),
    .present_time_out (present_time_out),
    .delivery_time_out(delivery_time_out),
    .frame_length_out (frame_length_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty)
        sb.check_result('{out_byte: out_byte, fend: fragment_end, marker: rtp_marker,
                          last: run_last, pts: present_time_out,
                          dts: delivery_time_out, flen: frame_length_out});
      pop <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("xiph_rtp_fragmenter_top test failed");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic s, input logic [15:0] len,
                           input logic [31:0] p, input logic [31:0] dl,
                           input logic [31:0] f);
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    data_byte <= d;
    packet_start <= s;
    packet_length <= len;
    present_time <= p;
    delivery_time <= dl;
    frame_length <= f;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_input(d, s, len, p, dl, f);
  endtask

  // Send nbytes of a packet whose declared length is len; fewer bytes
  // than len leave the packet open for the next start to abandon.
  task automatic send_packet(input logic [15:0] len, input int nbytes);
    int i;
    for (i = 0; i < nbytes; i++)
      send_byte(8'($urandom), i == 0, (i == 0) ? len : 16'($urandom),
                $urandom, $urandom, $urandom);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_ident(input logic [23:0] v);
    drain();
    stream_ident_we <= 1'b1;
    stream_ident <= v;
    @(posedge clk);
    stream_ident_we <= 1'b0;
    sb.ident = v;
  endtask

  task automatic random_traffic(input int target);
    int          sent;
    int          r;
    int          n;
    sent = 0;
    while (sent < target) begin
      r = $urandom_range(99);
      if (r < 6) begin
        // stray byte, or a continuation after an abandoned packet
        send_byte(8'($urandom), 1'b0, 16'($urandom), $urandom, $urandom, $urandom);
      end else if (r < 16) begin
        n = $urandom_range(1, 6);
        send_packet(16'($urandom), n);
        sent += n;
      end else if (r < 20) begin
        send_packet(16'd0, 1);
        sent++;
      end else begin
        n = $urandom_range(1, 24);
        send_packet(16'(n), n);
        sent += n;
      end
    end
  endtask

  task automatic run_phase(input logic [23:0] ident, input int idle, input int stall);
    set_ident(ident);
    sender_idle_pct = idle;
    receiver_stall_pct = stall;
    random_traffic(ITEMS_PER_PHASE);
  endtask

  initial begin
    sb = new();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    rst <= 1'b1;
    stream_ident_we <= 1'b0;
    stream_ident <= '0;
    push <= 1'b0;
    data_byte <= '0;
    packet_start <= 1'b0;
    packet_length <= '0;
    present_time <= '0;
    delivery_time <= '0;
    frame_length <= '0;
    pop <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_ident(24'hFFFFFF);
    send_byte(8'h00, 1'b1, 16'd1, 32'h0, 32'h0, 32'h0);
    send_byte(8'hFF, 1'b1, 16'd2, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_byte(8'h00, 1'b0, 16'h0000, 32'h0, 32'h0, 32'h0);
    send_byte(8'hA5, 1'b0, 16'hFFFF, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF);
    send_byte(8'h5A, 1'b1, 16'd0, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F);
    send_packet(16'hFFFF, 3);
    send_packet(MAX_PAYLOAD_W, 4);
    send_packet(MAX_PAYLOAD_W + 16'd1, 4);
    send_byte(8'h3C, 1'b0, 16'h8000, 32'h80000000, 32'h80000000, 32'h80000000);

    run_phase(24'h000000, 0, 0);
    run_phase(24'($urandom), 58, 0);
    run_phase(24'($urandom), 0, 58);
    run_phase(24'($urandom), 28, 28);

    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d input bytes (%0d ignored) and checked %0d output bytes.",
             sb.bytes_in, sb.ignored, sb.bytes_out);
    $display("Fragments: %0d whole, %0d first, %0d middle, %0d last; %0d mismatches.",
             sb.frag_count[0], sb.frag_count[1], sb.frag_count[2], sb.frag_count[3],
             sb.errors);
    if (sb.errors == 0) begin
      $display("xiph_rtp_fragmenter_top test passed");
    end else begin
      $display("xiph_rtp_fragmenter_top test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/xrf_pkg.sv
rtl/core/xrf_front.sv
rtl/core/xrf_queue.sv
rtl/core/xrf_back.sv
rtl/core/xiph_rtp_fragmenter_top.sv
dv/testbench.sv
